// File: rtl/dbpc_pkg.sv
// dbpc_pkg: shared types, command codes and constants of the dual blink period controller
// no dependencies; used by the parser, blinker and top-level modules and by the bench
`timescale 1ns / 1ps

package dbpc_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_BYTE      = 3'd1,
    CMD_BUTTON    = 3'd2,
    CMD_EVENT_ONE = 3'd3,
    CMD_EVENT_TWO = 3'd4
  } cmd_e;

  // characters of the command line
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [2:0] LED_ID_NONE = 3'd0;
  localparam logic [2:0] LED_ID_ONE  = 3'd1;
  localparam logic [2:0] LED_ID_TWO  = 3'd2;

  localparam logic [15:0] MS_PER_SEC   = 16'd1000;
  localparam logic [15:0] MS_PER_TENTH = 16'd100;
  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam logic [31:0] RECIP_TEN    = 32'd52429;
  localparam int          RECIP_SHIFT  = 19;

  localparam logic [15:0] PERIOD_ONE_RST = 16'd200;
  localparam logic [15:0] PERIOD_TWO_RST = 16'd100;
  localparam logic [15:0] PERIOD_STEP    = 16'd50;
  localparam logic [15:0] PERIOD_FLOOR   = 16'd100;
  localparam logic [15:0] PERIOD_RELOAD  = 16'd500;
  localparam logic [15:0] PERIOD_CEIL    = 16'd600;

  typedef struct packed {
    logic        line_done;
    logic        set_one;
    logic        set_two;
    logic [15:0] period;
  } line_evt_t;

  typedef struct packed {
    logic [3:0]  pins;
    logic [15:0] period_one;
    logic [15:0] period_two;
  } blink_st_t;

  function automatic logic [15:0] lower_period(input logic [15:0] p);
    return (p > PERIOD_FLOOR) ? (p - PERIOD_STEP) : PERIOD_RELOAD;
  endfunction

  function automatic logic [15:0] raise_period(input logic [15:0] p);
    logic [15:0] n;
    n = p + PERIOD_STEP;
    return (n >= PERIOD_CEIL) ? PERIOD_FLOOR : n;
  endfunction

endpackage

// File: rtl/dbpc_parser.sv
// dbpc_parser: command line parser for "L<id>:<int>.<tenth>" ended by CR or LF
// depends on dbpc_pkg
`timescale 1ns / 1ps

module dbpc_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [7:0]            rx_byte_i,
  output dbpc_pkg::line_evt_t   line_evt_o
);

  logic [2:0]  chosen_q, chosen_d;
  logic [15:0] ms_q, ms_d;       // whole seconds times 1000, mod 2^16
  logic [3:0]  tenth_q, tenth_d;
  logic        dot_q, dot_d;
  logic        started_q, started_d;

  logic        is_digit, is_id;
  logic [3:0]  digit;
  logic [15:0] ms_next, total_ms;
  logic [31:0] prod;

  assign is_digit = (rx_byte_i >= dbpc_pkg::CH_0) && (rx_byte_i <= dbpc_pkg::CH_9);
  assign is_id    = (rx_byte_i >= dbpc_pkg::CH_1) && (rx_byte_i <= dbpc_pkg::CH_4);
  assign digit    = rx_byte_i[3:0];

  // ms tracks whole_seconds * 1000 so no multiply is needed at the terminator
  assign ms_next  = (ms_q << 3) + (ms_q << 1) + ({12'b0, digit} * dbpc_pkg::MS_PER_SEC);
  assign total_ms = ms_q + ({12'b0, tenth_q} * dbpc_pkg::MS_PER_TENTH);
  assign prod     = {16'b0, total_ms} * dbpc_pkg::RECIP_TEN;

  always_comb begin
    chosen_d  = chosen_q;
    ms_d      = ms_q;
    tenth_d   = tenth_q;
    dot_d     = dot_q;
    started_d = started_q;
    line_evt_o.line_done = 1'b0;
    line_evt_o.set_one   = 1'b0;
    line_evt_o.set_two   = 1'b0;
    line_evt_o.period    = {3'b0, prod[31:dbpc_pkg::RECIP_SHIFT]};
    if (en_i) begin
      if (rx_byte_i == dbpc_pkg::CH_L) begin
        chosen_d  = dbpc_pkg::LED_ID_NONE;
        ms_d      = '0;
        tenth_d   = '0;
        dot_d     = 1'b0;
        started_d = 1'b1;
      end else if (started_q && chosen_q == dbpc_pkg::LED_ID_NONE && is_id) begin
        chosen_d = rx_byte_i[2:0];
      end else if (started_q && rx_byte_i == dbpc_pkg::CH_COLON) begin
        // separator
      end else if (started_q && is_digit) begin
        if (!dot_q) begin
          ms_d = ms_next;
        end else begin
          tenth_d = digit;
        end
      end else if (started_q && rx_byte_i == dbpc_pkg::CH_DOT) begin
        dot_d = 1'b1;
      end else if (rx_byte_i == dbpc_pkg::CH_CR || rx_byte_i == dbpc_pkg::CH_LF) begin
        line_evt_o.line_done = 1'b1;
        line_evt_o.set_one   = (chosen_q == dbpc_pkg::LED_ID_ONE);
        line_evt_o.set_two   = (chosen_q == dbpc_pkg::LED_ID_TWO);
        chosen_d  = dbpc_pkg::LED_ID_NONE;
        ms_d      = '0;
        tenth_d   = '0;
        dot_d     = 1'b0;
        started_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chosen_q  <= dbpc_pkg::LED_ID_NONE;
      ms_q      <= '0;
      tenth_q   <= '0;
      dot_q     <= 1'b0;
      started_q <= 1'b0;
    end else begin
      chosen_q  <= chosen_d;
      ms_q      <= ms_d;
      tenth_q   <= tenth_d;
      dot_q     <= dot_d;
      started_q <= started_d;
    end
  end

endmodule

// File: rtl/dbpc_blink.sv
// dbpc_blink: blink periods, tick counters, pin levels and button edge detection
// depends on dbpc_pkg; takes period writes from dbpc_parser
`timescale 1ns / 1ps

module dbpc_blink (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [2:0]            command_i,
  input  logic                  btn_dec1_level_i,
  input  logic                  btn_dec2_level_i,
  input  dbpc_pkg::line_evt_t   line_evt_i,
  output dbpc_pkg::blink_st_t   status_o
);

  logic [15:0] per_a_q, per_a_d, per_b_q, per_b_d;
  logic [15:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [3:0]  pins_q, pins_d;
  logic [1:0]  last_btn_q, last_btn_d;
  logic [15:0] cnt_a_inc, cnt_b_inc;

  assign cnt_a_inc = cnt_a_q + 16'd1;
  assign cnt_b_inc = cnt_b_q + 16'd1;

  always_comb begin
    per_a_d    = per_a_q;
    per_b_d    = per_b_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    pins_d     = pins_q;
    last_btn_d = last_btn_q;
    if (en_i) begin
      case (command_i)
        dbpc_pkg::CMD_TICK: begin
          // a counter meeting half its period restarts and flips its pin
          if (cnt_a_inc == (per_a_q >> 1)) begin
            cnt_a_d   = '0;
            pins_d[0] = ~pins_q[0];
          end else begin
            cnt_a_d = cnt_a_inc;
          end
          if (cnt_b_inc == (per_b_q >> 1)) begin
            cnt_b_d   = '0;
            pins_d[1] = ~pins_q[1];
          end else begin
            cnt_b_d = cnt_b_inc;
          end
        end
        dbpc_pkg::CMD_BYTE: begin
          if (line_evt_i.set_one) per_a_d = line_evt_i.period;
          if (line_evt_i.set_two) per_b_d = line_evt_i.period;
        end
        dbpc_pkg::CMD_BUTTON: begin
          if (!btn_dec1_level_i && last_btn_q[0]) per_a_d = dbpc_pkg::lower_period(per_a_q);
          if (!btn_dec2_level_i && last_btn_q[1]) per_b_d = dbpc_pkg::lower_period(per_b_q);
          last_btn_d = {btn_dec2_level_i, btn_dec1_level_i};
        end
        dbpc_pkg::CMD_EVENT_ONE: begin
          per_a_d   = dbpc_pkg::raise_period(per_a_q);
          pins_d[2] = ~pins_q[2];
        end
        dbpc_pkg::CMD_EVENT_TWO: begin
          per_b_d   = dbpc_pkg::raise_period(per_b_q);
          pins_d[3] = ~pins_q[3];
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o.pins       = pins_d;
  assign status_o.period_one = per_a_d;
  assign status_o.period_two = per_b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_a_q    <= dbpc_pkg::PERIOD_ONE_RST;
      per_b_q    <= dbpc_pkg::PERIOD_TWO_RST;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      pins_q     <= '1;
      last_btn_q <= '1;
    end else begin
      per_a_q    <= per_a_d;
      per_b_q    <= per_b_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      pins_q     <= pins_d;
      last_btn_q <= last_btn_d;
    end
  end

endmodule

// File: rtl/dual_blink_period_controller.sv
// dual blink period controller: input register, parser, blinker state and result register
// path: an accepted item passes the input register, then the result register, and waits while a result is stalled
// throughput: one item per cycle while the output is not stalled, set by the combinational state update
// reset: periods 200 and 100, counters and parser cleared, all pins high (leds off)
// depends on dbpc_pkg, dbpc_parser and dbpc_blink
`timescale 1ns / 1ps

module dual_blink_period_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        btn_dec1_level_i,
  input  logic        btn_dec2_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        led1_level_o,
  output logic        led2_level_o,
  output logic        led3_level_o,
  output logic        led4_level_o,
  output logic [15:0] period_one_o,
  output logic [15:0] period_two_o,
  output logic        line_done_o,
  output logic        period_written_o
);

  logic        in_valid_q, in_valid_d;
  logic [2:0]  cmd_q;
  logic [7:0]  byte_q;
  logic        btn1_q, btn2_q;
  logic        out_valid_q, out_valid_d;
  logic        advance, accept;

  dbpc_pkg::line_evt_t line_evt;
  dbpc_pkg::blink_st_t status;
  dbpc_pkg::blink_st_t res_st_q;
  logic                res_done_q, res_written_q;

  // the item in the input register steps when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);

  dbpc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance && cmd_q == dbpc_pkg::CMD_BYTE),
    .rx_byte_i  (byte_q),
    .line_evt_o (line_evt)
  );

  dbpc_blink u_blink (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .command_i        (cmd_q),
    .btn_dec1_level_i (btn1_q),
    .btn_dec2_level_i (btn2_q),
    .line_evt_i       (line_evt),
    .status_o         (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      byte_q <= rx_byte_i;
      btn1_q <= btn_dec1_level_i;
      btn2_q <= btn_dec2_level_i;
    end
    if (advance) begin
      res_st_q      <= status;
      res_done_q    <= line_evt.line_done;
      res_written_q <= line_evt.set_one || line_evt.set_two;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led1_level_o     = res_st_q.pins[0];
  assign led2_level_o     = res_st_q.pins[1];
  assign led3_level_o     = res_st_q.pins[2];
  assign led4_level_o     = res_st_q.pins[3];
  assign period_one_o     = res_st_q.period_one;
  assign period_two_o     = res_st_q.period_two;
  assign line_done_o      = res_done_q;
  assign period_written_o = res_written_q;

endmodule

// File: rtl/dbpc_checker.sv
// dbpc_checker: port-level assertions for the dual blink period controller
// bound to dual_blink_period_controller; no package dependency
`timescale 1ns / 1ps

module dbpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] period_one_o,
  input logic        line_done_o,
  input logic        period_written_o
);

  // a period write only ever comes from a finished line
  a_written_needs_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && period_written_o |-> line_done_o)
    else $error("period written without end of line");

  // an accepted item is followed by a valid result at the output
  a_item_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted item produced no result");

  // input stalls only while a result is waiting
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result stage");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(period_one_o))
    else $error("stalled result changed");

endmodule

bind dual_blink_period_controller dbpc_checker u_dbpc_checker (.*);

// File: sim/tb.sv
// tb: self-checking bench for dual_blink_period_controller with a cycle-level state predictor
// depends on dbpc_pkg and the rtl under rtl/; no files or arguments needed
`timescale 1ns / 1ps

module tb;

  // command codes the block ignores
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
  localparam int         CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [3:0]  pins;
    logic [15:0] per_one;
    logic [15:0] per_two;
    logic        done;
    logic        written;
  } blink_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic [7:0]  rx_byte;
  logic        btn_dec1;
  logic        btn_dec2;
  logic        out_valid;
  logic        out_stall;
  logic        led1, led2, led3, led4;
  logic [15:0] period_one;
  logic [15:0] period_two;
  logic        line_done;
  logic        period_written;

  // predicted block state
  logic [15:0] blink_per_one, blink_per_two;
  logic [15:0] blink_cnt_one, blink_cnt_two;
  logic [3:0]  pin_state;
  logic [2:0]  parse_led;
  logic [15:0] parse_secs;
  logic [3:0]  parse_tenth;
  logic        parse_dot;
  logic        parse_open;
  logic [1:0]  btn_prev;

  blink_res_t  blink_expect_q[$];
  int          items_sent;
  int          results_seen;
  int          n_errors;
  int          cycle_cnt;
  int          hold_req;
  bit          tx_idle_on;
  bit          rx_idle_on;

  dual_blink_period_controller dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .rx_byte_i        (rx_byte),
    .btn_dec1_level_i (btn_dec1),
    .btn_dec2_level_i (btn_dec2),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .led1_level_o     (led1),
    .led2_level_o     (led2),
    .led3_level_o     (led3),
    .led4_level_o     (led4),
    .period_one_o     (period_one),
    .period_two_o     (period_two),
    .line_done_o      (line_done),
    .period_written_o (period_written)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               blink_expect_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] stepped_down(input logic [15:0] p);
    if (p > dbpc_pkg::PERIOD_FLOOR) return p - dbpc_pkg::PERIOD_STEP;
    return dbpc_pkg::PERIOD_RELOAD;
  endfunction

  function automatic logic [15:0] stepped_up(input logic [15:0] p);
    logic [15:0] sum;
    sum = p + dbpc_pkg::PERIOD_STEP;
    if (sum >= dbpc_pkg::PERIOD_CEIL) return dbpc_pkg::PERIOD_FLOOR;
    return sum;
  endfunction

  task automatic clear_line_parse();
    parse_led   = dbpc_pkg::LED_ID_NONE;
    parse_secs  = '0;
    parse_tenth = '0;
    parse_dot   = 1'b0;
  endtask

  task automatic step_blink_model(input logic [2:0] cmd, input logic [7:0] c,
                                  input logic b1, input logic b2);
    blink_res_t  res;
    logic [31:0] ms_full;
    logic [15:0] new_per;
    logic        done;
    logic        written;
    done    = 1'b0;
    written = 1'b0;
    case (cmd)
      dbpc_pkg::CMD_TICK: begin
        blink_cnt_one = blink_cnt_one + 16'd1;
        if (blink_cnt_one == (blink_per_one >> 1)) begin
          pin_state[0]  = ~pin_state[0];
          blink_cnt_one = '0;
        end
        blink_cnt_two = blink_cnt_two + 16'd1;
        if (blink_cnt_two == (blink_per_two >> 1)) begin
          pin_state[1]  = ~pin_state[1];
          blink_cnt_two = '0;
        end
      end
      dbpc_pkg::CMD_BYTE: begin
        if (c == dbpc_pkg::CH_L) begin
          clear_line_parse();
          parse_open = 1'b1;
        end else if (parse_open && parse_led == dbpc_pkg::LED_ID_NONE &&
                     c >= dbpc_pkg::CH_1 && c <= dbpc_pkg::CH_4) begin
          parse_led = 3'(c - dbpc_pkg::CH_0);
        end else if (parse_open && c == dbpc_pkg::CH_COLON) begin
          // separator only
        end else if (parse_open && c >= dbpc_pkg::CH_0 && c <= dbpc_pkg::CH_9) begin
          if (!parse_dot) parse_secs = parse_secs * 16'd10 + {8'd0, 8'(c - dbpc_pkg::CH_0)};
          else parse_tenth = 4'(c - dbpc_pkg::CH_0);
        end else if (parse_open && c == dbpc_pkg::CH_DOT) begin
          parse_dot = 1'b1;
        end else if (c == dbpc_pkg::CH_CR || c == dbpc_pkg::CH_LF) begin
          // ms value is cut to 16 bits before the divide
          ms_full = {16'd0, parse_secs} * {16'd0, dbpc_pkg::MS_PER_SEC}
                  + {28'd0, parse_tenth} * {16'd0, dbpc_pkg::MS_PER_TENTH};
          new_per = ms_full[15:0] / 16'd10;
          done    = 1'b1;
          if (parse_led == dbpc_pkg::LED_ID_ONE) begin
            blink_per_one = new_per;
            written       = 1'b1;
          end else if (parse_led == dbpc_pkg::LED_ID_TWO) begin
            blink_per_two = new_per;
            written       = 1'b1;
          end
          parse_open = 1'b0;
          clear_line_parse();
        end
      end
      dbpc_pkg::CMD_BUTTON: begin
        if (!b1 && btn_prev[0]) blink_per_one = stepped_down(blink_per_one);
        if (!b2 && btn_prev[1]) blink_per_two = stepped_down(blink_per_two);
        btn_prev = {b2, b1};
      end
      dbpc_pkg::CMD_EVENT_ONE: begin
        blink_per_one = stepped_up(blink_per_one);
        pin_state[2]  = ~pin_state[2];
      end
      dbpc_pkg::CMD_EVENT_TWO: begin
        pin_state[3]  = ~pin_state[3];
        blink_per_two = stepped_up(blink_per_two);
      end
      default: begin
      end
    endcase
    res.pins    = pin_state;
    res.per_one = blink_per_one;
    res.per_two = blink_per_two;
    res.done    = done;
    res.written = written;
    blink_expect_q.push_back(res);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name, got,
                             want));
  endtask

  always @(posedge clk) begin : result_check
    blink_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (blink_expect_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with no item outstanding", results_seen));
      end else begin
        want = blink_expect_q.pop_front();
        check_field("led1_level", {15'd0, led1}, {15'd0, want.pins[0]});
        check_field("led2_level", {15'd0, led2}, {15'd0, want.pins[1]});
        check_field("led3_level", {15'd0, led3}, {15'd0, want.pins[2]});
        check_field("led4_level", {15'd0, led4}, {15'd0, want.pins[3]});
        check_field("period_one", period_one, want.per_one);
        check_field("period_two", period_two, want.per_two);
        check_field("line_done", {15'd0, line_done}, {15'd0, want.done});
        check_field("period_written", {15'd0, period_written}, {15'd0, want.written});
      end
      results_seen++;
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rnd_digit();
    return dbpc_pkg::CH_0 + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [7:0] c,
                           input logic b1, input logic b2);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    command  <= cmd;
    rx_byte  <= c;
    btn_dec1 <= b1;
    btn_dec2 <= b2;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_blink_model(cmd, c, b1, b2);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_item(dbpc_pkg::CMD_BYTE, c, rnd_bit(), rnd_bit());
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (blink_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic do_reset();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    command  = dbpc_pkg::CMD_TICK;
    rx_byte  = '0;
    btn_dec1 = 1'b1;
    btn_dec2 = 1'b1;
    blink_per_one = dbpc_pkg::PERIOD_ONE_RST;
    blink_per_two = dbpc_pkg::PERIOD_TWO_RST;
    blink_cnt_one = '0;
    blink_cnt_two = '0;
    pin_state     = 4'hF;
    parse_open    = 1'b0;
    clear_line_parse();
    btn_prev      = 2'b11;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
  endtask

  // line with random content, now and then with a missing or odd id or a stray byte in it
  task automatic send_random_line();
    int id_pick;
    send_byte(dbpc_pkg::CH_L);
    id_pick = $urandom_range(0, 11);
    if (id_pick < 4) send_byte(dbpc_pkg::CH_1);
    else if (id_pick < 8) send_byte(dbpc_pkg::CH_0 + 8'd2);
    else if (id_pick == 8) send_byte(dbpc_pkg::CH_0 + 8'd3);
    else if (id_pick == 9) send_byte(dbpc_pkg::CH_4);
    else if (id_pick == 10) send_byte(rnd_digit());
    if (rnd_bit()) send_byte(dbpc_pkg::CH_COLON);
    if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 5)) send_byte(rnd_digit());
    if ($urandom_range(0, 7) == 0) send_byte(rnd_byte());
    if ($urandom_range(0, 2) != 0) begin
      send_byte(dbpc_pkg::CH_DOT);
      repeat ($urandom_range(0, 2)) send_byte(rnd_digit());
    end
    send_byte(rnd_bit() ? dbpc_pkg::CH_CR : dbpc_pkg::CH_LF);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_unused_commands();
    for (int k = CMD_RSVD_FIRST; k <= CMD_RSVD_LAST; k++)
      send_item(3'(k), 8'hFF, 1'b0, 1'b0);
  endtask

  task automatic test_buttons();
    send_item(dbpc_pkg::CMD_BUTTON, 8'h00, 1'b0, 1'b1);
    // period two already at the floor, so it reloads
    send_item(dbpc_pkg::CMD_BUTTON, 8'h00, 1'b0, 1'b0);
    send_item(dbpc_pkg::CMD_BUTTON, 8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_events();
    send_item(dbpc_pkg::CMD_EVENT_ONE, 8'h00, 1'b1, 1'b1);
    send_item(dbpc_pkg::CMD_EVENT_TWO, 8'h00, 1'b1, 1'b1);
    // 550 + 50 reaches the ceiling and wraps to the floor
    send_item(dbpc_pkg::CMD_EVENT_TWO, 8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_ticks();
    repeat (2) send_item(dbpc_pkg::CMD_TICK, 8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_command_lines();
    send_text("L1:9.9");
    send_byte(dbpc_pkg::CH_CR);
    // terminator with no line open
    send_byte(dbpc_pkg::CH_LF);
    send_text("L3:2");
    send_byte(dbpc_pkg::CH_LF);
  endtask

  task automatic test_output_holdoff();
    hold_req = 80;
    repeat (30) begin
      if (rnd_bit()) send_item(dbpc_pkg::CMD_TICK, rnd_byte(), rnd_bit(), rnd_bit());
      else send_byte(rnd_byte());
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int first;
    int kind;
    first = items_sent;
    while (items_sent - first < n_items) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: send_random_line();
        3, 4, 5: repeat ($urandom_range(1, 20))
                   send_item(dbpc_pkg::CMD_TICK, rnd_byte(), rnd_bit(), rnd_bit());
        6: send_item(dbpc_pkg::CMD_BUTTON, rnd_byte(), rnd_bit(), rnd_bit());
        7: send_item(rnd_bit() ? dbpc_pkg::CMD_EVENT_ONE : dbpc_pkg::CMD_EVENT_TWO,
                     rnd_byte(), rnd_bit(), rnd_bit());
        8: send_byte(rnd_byte());
        default: send_item(3'($urandom_range(0, 7)), rnd_byte(), rnd_bit(), rnd_bit());
      endcase
    end
  endtask

  // zero periods give a half period of zero: the counters keep counting without a match
  task automatic test_slow_period_wrap();
    send_text("L1:0");
    send_byte(dbpc_pkg::CH_CR);
    send_text("L2:0.0");
    send_byte(dbpc_pkg::CH_LF);
    repeat (20) send_item(dbpc_pkg::CMD_TICK, 8'h00, 1'b1, 1'b1);
  endtask

  initial begin
    items_sent   = 0;
    results_seen = 0;
    n_errors     = 0;
    cycle_cnt    = 0;
    hold_req     = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    do_reset();

    test_unused_commands();
    test_buttons();
    test_events();
    test_ticks();
    test_command_lines();
    test_output_holdoff();
    test_random_traffic(720);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(250);
    test_slow_period_wrap();

    wait_drained();
    repeat (10) @(negedge clk);
    while (blink_expect_q.size() != 0) begin
      void'(blink_expect_q.pop_front());
      report_error("expected result never arrived");
    end
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dbpc_pkg.sv
rtl/dbpc_parser.sv
rtl/dbpc_blink.sv
rtl/dual_blink_period_controller.sv
rtl/dbpc_checker.sv
sim/tb.sv
